// ----- rtl/ostb_pkg.sv -----
// Package for the one-shot tick timer bank.
// Holds slot count, widths, opcode and slot mode types, and the cell command struct.
// No dependencies.
package ostb_pkg;

	localparam int NUM_SLOTS = 8;
	localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CMP_W     = ((IDX_W > 3) ? IDX_W : 3) + 1;
	localparam int MASK_W    = 8;
	localparam int CNT_W     = 16;
	localparam int TICK_W    = 32;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_ARM   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		MODE_DISARMED = 2'd0,
		MODE_ARMED    = 2'd1,
		MODE_PENDING  = 2'd2
	} mode_t;

	typedef struct packed {
		logic             tick;
		logic             arm;
		logic [2:0]       slot;
		logic [CNT_W-1:0] count;
		logic             cb;
	} cmd_t;

endpackage

// ----- rtl/ostb_cell.sv -----
// One timer slot of the bank: mode, remaining count and callback flag.
// Adds its fire bit and queried state onto the chain from its lower neighbor.
// Depends on ostb_pkg.
module ostb_cell
	import ostb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CMP_W-1:0]  idx,
	input  cmd_t              cmd,
	input  logic [MASK_W-1:0] mask_in,
	input  logic [1:0]        state_in,
	output logic [MASK_W-1:0] mask_out,
	output logic [1:0]        state_out
);

	mode_t            mode_q;
	logic [CNT_W-1:0] rem_q;
	logic             cb_q;
	logic             match;
	logic             fire;
	logic [MASK_W-1:0] fire_bit;

	assign match = ({{(CMP_W-3){1'b0}}, cmd.slot} == idx);
	assign fire  = cmd.tick && (mode_q == MODE_ARMED) && (rem_q == '0);

	always_comb begin
		fire_bit = '0;
		if (fire && (idx < CMP_W'(MASK_W))) begin
			fire_bit = MASK_W'(1) << idx[2:0];
		end
	end

	assign mask_out  = mask_in | fire_bit;
	assign state_out = state_in | (match ? mode_q : 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DISARMED;
		end else if (cmd.arm && match) begin
			mode_q <= MODE_ARMED;
		end else if (fire) begin
			mode_q <= cb_q ? MODE_DISARMED : MODE_PENDING;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.arm && match) begin
			rem_q <= cmd.count;
			cb_q  <= cmd.cb;
		end else if (cmd.tick && (mode_q == MODE_ARMED) && (rem_q != '0)) begin
			rem_q <= rem_q - CNT_W'(1);
		end
	end

endmodule

// ----- rtl/one_shot_tick_timer_bank_unit.sv -----
// Top level of the one-shot tick timer bank: command decode, tick counter,
// row of ostb_cell slots and the result register.
// Depends on ostb_pkg and ostb_cell.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+---------------------
//  command | op, slot, start_count, has_callback           | start && !busy
//  result  | tick_total, fired_mask, slot_state            | done, one cycle
//
// One item per cycle; its result is registered and shows in the cycle after the transfer.
// The row of cells acts on all slots in the transfer cycle, so busy stays low.
// Reset clears the tick counter and sets every slot disarmed at once.
// The receiver cannot stall; done is a one-cycle strobe.
module one_shot_tick_timer_bank_unit
	import ostb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        op,
	input  logic [2:0]        slot,
	input  logic [CNT_W-1:0]  start_count,
	input  logic              has_callback,
	output logic              done,
	output logic [TICK_W-1:0] tick_total,
	output logic [MASK_W-1:0] fired_mask,
	output logic [1:0]        slot_state
);

	logic              xfer;
	cmd_t              cmd;
	logic [TICK_W-1:0] tick_cnt_q;
	logic [TICK_W-1:0] tick_nxt;
	logic              done_q;
	logic [TICK_W-1:0] tick_total_q;
	logic [MASK_W-1:0] fired_mask_q;
	logic [1:0]        slot_state_q;
	logic [MASK_W-1:0] mask_chain [NUM_SLOTS+1];
	logic [1:0]        state_chain [NUM_SLOTS+1];

	assign busy = 1'b0;
	assign xfer = start && !busy;

	always_comb begin
		cmd.tick  = xfer && (op == OP_TICK);
		cmd.arm   = xfer && (op == OP_ARM);
		cmd.slot  = slot;
		cmd.count = start_count;
		cmd.cb    = has_callback;
	end

	assign mask_chain[0]  = '0;
	assign state_chain[0] = '0;

	for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
		ostb_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (CMP_W'(k)),
			.cmd       (cmd),
			.mask_in   (mask_chain[k]),
			.state_in  (state_chain[k]),
			.mask_out  (mask_chain[k+1]),
			.state_out (state_chain[k+1])
		);
	end

	assign tick_nxt = cmd.tick ? (tick_cnt_q + TICK_W'(1)) : tick_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			tick_cnt_q <= tick_nxt;
			done_q     <= xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			tick_total_q <= tick_nxt;
			fired_mask_q <= cmd.tick ? mask_chain[NUM_SLOTS] : '0;
			slot_state_q <= (op == OP_QUERY) ? state_chain[NUM_SLOTS] : 2'd0;
		end
	end

	assign done       = done_q;
	assign tick_total = tick_total_q;
	assign fired_mask = fired_mask_q;
	assign slot_state = slot_state_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("transfer without result strobe");

	a_mask_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(op) != OP_TICK)) |-> (fired_mask == '0))
		else $error("fired mask set on non-tick item");

	a_state_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(op) != OP_QUERY)) |-> (slot_state == 2'd0))
		else $error("slot state set on non-query item");

	a_tick_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(op) == OP_TICK)) |-> (tick_total == $past(tick_cnt_q) + TICK_W'(1)))
		else $error("tick total did not advance on tick");

endmodule
